// File: sv/gre_pkg.sv
`default_nettype none

package gre_pkg;

   localparam int FRAC_BITS = 58;
   localparam int MAG_W = 61;
   localparam int PROD_W = 70;
   localparam int T_W = 63;
   localparam int Y_W = 63;
   localparam int COEF_W = 62;
   localparam int GAMMA_W = 13;
   localparam int ENTRY_W = 16;
   localparam int REM_W = 13;
   localparam int EXPN_W = 5;
   localparam int STEP_W = 6;

   localparam logic [GAMMA_W-1:0] GAMMA_MIN = 13'd100;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 13'd400;
   localparam logic signed [6:0] BRIGHT_MIN = -7'sd50;
   localparam logic signed [6:0] BRIGHT_MAX = 7'sd50;
   localparam logic [ENTRY_W-1:0] SCALE_WIDE = 16'd65535;
   localparam logic [ENTRY_W-1:0] SCALE_NARROW = 16'd255;

   typedef enum logic [2:0] {
      REG_RED_GAMMA = 3'd0,
      REG_GREEN_GAMMA = 3'd1,
      REG_BLUE_GAMMA = 3'd2,
      REG_BRIGHTNESS = 3'd3,
      REG_NARROW = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } tag_type;

   typedef logic [MAG_W-1:0] mag_table_type [256];
   typedef logic [COEF_W-1:0] exp_coef_type [FRAC_BITS];

   function automatic logic [MAG_W-1:0] log2_fixed(input logic [7:0] v);
      logic [127:0] x;
      logic [MAG_W-1:0] r;
      int m;
      m = 0;
      for (int j = 1; j < 8; j++) begin
         if ((v >> j) != 8'd0) begin
            m = j;
         end
      end
      x = 128'(v) << (62 - m);
      r = MAG_W'(m) << FRAC_BITS;
      for (int k = 0; k < FRAC_BITS; k++) begin
         x = (x * x) >> 62;
         if (x >= (128'd1 << 63)) begin
            x = x >> 1;
            r[FRAC_BITS-1-k] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic mag_table_type build_mag_table();
      mag_table_type tab;
      logic [MAG_W-1:0] top;
      top = log2_fixed(8'd255);
      tab[0] = '0;
      for (int v = 1; v < 256; v++) begin
         tab[v] = top - log2_fixed(8'(v));
      end
      return tab;
   endfunction

   // Each coefficient is (1 - 2^(-2^-(i+1))) * 2^(i+1) with 62 fraction bits.
   function automatic exp_coef_type build_exp_coef();
      exp_coef_type tab;
      logic [255:0] c;
      logic [255:0] x;
      logic [255:0] res;
      logic [255:0] trial;
      c = 256'd1 << 125;
      for (int i = 0; i < FRAC_BITS; i++) begin
         x = c << 126;
         res = '0;
         for (int b = 127; b >= 0; b--) begin
            trial = res | (256'd1 << b);
            if ((trial * trial) <= x) begin
               res = trial;
            end
         end
         c = res;
         tab[i] = COEF_W'(((((256'd1 << 126) - c) << (i + 1)) + (256'd1 << 63)) >> 64);
      end
      return tab;
   endfunction

   localparam mag_table_type MAG_TABLE = build_mag_table();
   localparam exp_coef_type EXP_COEF = build_exp_coef();

endpackage

`default_nettype wire

// File: sv/gre_div_cell.sv
`default_nettype none

module gre_div_cell
   import gre_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic [GAMMA_W-1:0] gamma,
   input  wire tag_type            in_tag,
   input  wire logic [REM_W-1:0]   in_rem,
   input  wire logic [T_W-1:0]     in_work,
   output tag_type                 out_tag,
   output logic [REM_W-1:0]        out_rem,
   output logic [T_W-1:0]          out_work
);

   tag_type tag_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [T_W-1:0] work_ff, work_in;
   logic [REM_W:0] trial;
   logic ge;

   always_comb begin
      trial = {in_rem, in_work[T_W-1]};
      ge = trial >= {1'b0, gamma};
      rem_in = ge ? REM_W'(trial - {1'b0, gamma}) : trial[REM_W-1:0];
      work_in = {in_work[T_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         work_ff <= work_in;
      end
   end

   assign out_tag = tag_ff;
   assign out_rem = rem_ff;
   assign out_work = work_ff;

endmodule

`default_nettype wire

// File: sv/gre_exp_cell.sv
`default_nettype none

module gre_exp_cell
   import gre_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic [COEF_W-1:0]    coef,
   input  wire logic [STEP_W-1:0]    step,
   input  wire tag_type              in_tag,
   input  wire logic [Y_W-1:0]       in_y,
   input  wire logic [FRAC_BITS-1:0] in_frac,
   input  wire logic [EXPN_W-1:0]    in_n,
   output tag_type                   out_tag,
   output logic [Y_W-1:0]            out_y,
   output logic [FRAC_BITS-1:0]      out_frac,
   output logic [EXPN_W-1:0]         out_n
);

   tag_type a_tag_ff, b_tag_ff;
   logic [Y_W-1:0] a_y_ff, b_y_ff, b_y_in;
   logic a_bit_ff;
   logic [FRAC_BITS-1:0] a_frac_ff, b_frac_ff;
   logic [EXPN_W-1:0] a_n_ff, b_n_ff;
   logic [62:0] p_hh_ff, p_hh_in, p_hl_ff, p_hl_in, p_lh_ff, p_lh_in;
   logic [125:0] full;
   logic [Y_W-1:0] dec;

   always_comb begin
      p_hh_in = 63'(64'(in_y[62:31]) * 64'(coef[61:31]));
      p_hl_in = 63'(64'(in_y[62:31]) * 64'(coef[30:0]));
      p_lh_in = 63'(64'(in_y[30:0]) * 64'(coef[61:31]));
   end

   always_comb begin
      full = (126'(p_hh_ff) << 62) + (126'(64'(p_hl_ff) + 64'(p_lh_ff)) << 31);
      dec = Y_W'(full >> (7'd63 + 7'(step)));
      b_y_in = a_bit_ff ? (a_y_ff - dec) : a_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
      end else if (adv) begin
         a_tag_ff <= in_tag;
         b_tag_ff <= a_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_y_ff <= in_y;
         a_bit_ff <= in_frac[FRAC_BITS-1];
         a_frac_ff <= {in_frac[FRAC_BITS-2:0], 1'b0};
         a_n_ff <= in_n;
         p_hh_ff <= p_hh_in;
         p_hl_ff <= p_hl_in;
         p_lh_ff <= p_lh_in;
         b_y_ff <= b_y_in;
         b_frac_ff <= a_frac_ff;
         b_n_ff <= a_n_ff;
      end
   end

   assign out_tag = b_tag_ff;
   assign out_y = b_y_ff;
   assign out_frac = b_frac_ff;
   assign out_n = b_n_ff;

endmodule

`default_nettype wire

// File: sv/gre_lane.sv
`default_nettype none

module gre_lane
   import gre_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic [GAMMA_W-1:0] gamma,
   input  wire logic [ENTRY_W-1:0] scale,
   input  wire tag_type            in_tag,
   input  wire logic [MAG_W-1:0]   in_mag,
   output tag_type                 out_tag,
   output logic [ENTRY_W-1:0]      out_entry
);

   tag_type prod_tag_ff, f1_tag_ff, f2_tag_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [78:0] sp_ff, sp_in;
   logic [EXPN_W-1:0] f1_n_ff;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [6:0] shamt;
   logic [95:0] rnd;
   logic [95:0] res;

   tag_type div_tag [T_W+1];
   logic [REM_W-1:0] div_rem [T_W+1];
   logic [T_W-1:0] div_work [T_W+1];

   tag_type exp_tag [FRAC_BITS+1];
   logic [Y_W-1:0] exp_y [FRAC_BITS+1];
   logic [FRAC_BITS-1:0] exp_frac [FRAC_BITS+1];
   logic [EXPN_W-1:0] exp_n [FRAC_BITS+1];

   assign prod_in = (PROD_W'(in_mag) << 8) + (PROD_W'(in_mag) << 7) + (PROD_W'(in_mag) << 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_tag_ff <= '0;
      end else if (adv) begin
         prod_tag_ff <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   assign div_tag[0] = prod_tag_ff;
   assign div_rem[0] = REM_W'(prod_ff[PROD_W-1:T_W]);
   assign div_work[0] = prod_ff[T_W-1:0];

   for (genvar i = 0; i < T_W; i++) begin : g_div
      gre_div_cell u_div (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .gamma   (gamma),
         .in_tag  (div_tag[i]),
         .in_rem  (div_rem[i]),
         .in_work (div_work[i]),
         .out_tag (div_tag[i+1]),
         .out_rem (div_rem[i+1]),
         .out_work(div_work[i+1])
      );
   end

   assign exp_tag[0] = div_tag[T_W];
   assign exp_y[0] = Y_W'(1) << 62;
   assign exp_frac[0] = div_work[T_W][FRAC_BITS-1:0];
   assign exp_n[0] = div_work[T_W][T_W-1:FRAC_BITS];

   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_exp
      gre_exp_cell u_exp (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .coef    (EXP_COEF[i]),
         .step    (STEP_W'(i)),
         .in_tag  (exp_tag[i]),
         .in_y    (exp_y[i]),
         .in_frac (exp_frac[i]),
         .in_n    (exp_n[i]),
         .out_tag (exp_tag[i+1]),
         .out_y   (exp_y[i+1]),
         .out_frac(exp_frac[i+1]),
         .out_n   (exp_n[i+1])
      );
   end

   assign sp_in = ((scale == SCALE_NARROW) ? (79'(exp_y[FRAC_BITS]) << 8)
                                           : (79'(exp_y[FRAC_BITS]) << 16))
                  - 79'(exp_y[FRAC_BITS]);

   always_comb begin
      shamt = 7'd62 + 7'(f1_n_ff);
      rnd = 96'(sp_ff) + (96'd1 << (shamt - 7'd1));
      res = rnd >> shamt;
      if (res > 96'(scale)) begin
         res = 96'(scale);
      end
      entry_in = f1_tag_ff.zero ? '0 : res[ENTRY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_tag_ff <= '0;
         f2_tag_ff <= '0;
      end else if (adv) begin
         f1_tag_ff <= exp_tag[FRAC_BITS];
         f2_tag_ff <= f1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sp_ff <= sp_in;
         f1_n_ff <= exp_n[FRAC_BITS];
         entry_ff <= entry_in;
      end
   end

   assign out_tag = f2_tag_ff;
   assign out_entry = entry_ff;

endmodule

`default_nettype wire

// File: sv/gamma_ramp_entry_generator.sv
// Gamma ramp entry generator.
// The req_ channel takes one ramp index per beat; the rsp_ channel returns one
// beat per index carrying the red, green and blue ramp entries, in order.
// Gamma, brightness and entry width are set through the APB-style port and
// should only be changed while no beat is in flight.
// Throughput is one beat per cycle while the receiver does not stall. Each
// request passes through the offset and log lookup register, the register for
// the product by 400, 63 cells of the bit-serial divider and 58 two-stage cells
// of the exp2 product chain, then the scaling and rounding registers.
// An output register and a skid register sit after the pipeline; when the
// receiver stalls, the skid register fills and the whole pipeline then holds,
// dropping req_ready, until the receiver takes a beat again.
// Reset empties the pipeline and loads the configuration registers with their defaults.
`default_nettype none

module gamma_ramp_entry_generator
   import gre_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ramp_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_red_entry,
   output logic [15:0]      rsp_green_entry,
   output logic [15:0]      rsp_blue_entry,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [GAMMA_W-1:0] red_gamma_ff, green_gamma_ff, blue_gamma_ff;
   logic signed [6:0] bright_ff;
   logic narrow_ff;
   csr_index_type csr_index;
   logic csr_write;

   logic adv;
   logic signed [6:0] b_sat;
   logic signed [9:0] v_sum;
   logic [7:0] v;
   tag_type front_tag_ff, front_tag_in;
   logic [MAG_W-1:0] front_mag_ff;
   logic [GAMMA_W-1:0] red_g, green_g, blue_g;
   logic [ENTRY_W-1:0] scale;

   tag_type red_tag, green_tag, blue_tag;
   logic [ENTRY_W-1:0] red_entry, green_entry, blue_entry;

   logic push, pop;
   logic main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic [ENTRY_W-1:0] main_r_ff, main_g_ff, main_b_ff, main_r_in, main_g_in, main_b_in;
   logic [ENTRY_W-1:0] skid_r_ff, skid_g_ff, skid_b_ff, skid_r_in, skid_g_in, skid_b_in;

   assign pready = 1'b1;
   assign csr_index = csr_index_type'(paddr[4:2]);
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_gamma_ff <= GAMMA_RESET;
         green_gamma_ff <= GAMMA_RESET;
         blue_gamma_ff <= GAMMA_RESET;
         bright_ff <= '0;
         narrow_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RED_GAMMA: red_gamma_ff <= pwdata[GAMMA_W-1:0];
            REG_GREEN_GAMMA: green_gamma_ff <= pwdata[GAMMA_W-1:0];
            REG_BLUE_GAMMA: blue_gamma_ff <= pwdata[GAMMA_W-1:0];
            REG_BRIGHTNESS: bright_ff <= $signed(pwdata[6:0]);
            REG_NARROW: narrow_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_RED_GAMMA: prdata = 32'(red_gamma_ff);
         REG_GREEN_GAMMA: prdata = 32'(green_gamma_ff);
         REG_BLUE_GAMMA: prdata = 32'(blue_gamma_ff);
         REG_BRIGHTNESS: prdata = {25'd0, bright_ff};
         REG_NARROW: prdata = {31'd0, narrow_ff};
         default: prdata = '0;
      endcase
   end

   assign adv = !skid_valid_ff;
   assign req_ready = adv;

   always_comb begin
      if (bright_ff < BRIGHT_MIN) begin
         b_sat = BRIGHT_MIN;
      end else if (bright_ff > BRIGHT_MAX) begin
         b_sat = BRIGHT_MAX;
      end else begin
         b_sat = bright_ff;
      end
      v_sum = $signed({2'b00, req_ramp_index}) + $signed({{3{b_sat[6]}}, b_sat});
      if (v_sum < 10'sd0) begin
         v = 8'd0;
      end else if (v_sum > 10'sd255) begin
         v = 8'd255;
      end else begin
         v = v_sum[7:0];
      end
      front_tag_in.valid = req_valid;
      front_tag_in.zero = (v == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_tag_ff <= '0;
      end else if (adv) begin
         front_tag_ff <= front_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_mag_ff <= MAG_TABLE[v];
      end
   end

   assign red_g = (red_gamma_ff < GAMMA_MIN) ? GAMMA_MIN : red_gamma_ff;
   assign green_g = (green_gamma_ff < GAMMA_MIN) ? GAMMA_MIN : green_gamma_ff;
   assign blue_g = (blue_gamma_ff < GAMMA_MIN) ? GAMMA_MIN : blue_gamma_ff;
   assign scale = narrow_ff ? SCALE_NARROW : SCALE_WIDE;

   gre_lane u_red (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .gamma    (red_g),
      .scale    (scale),
      .in_tag   (front_tag_ff),
      .in_mag   (front_mag_ff),
      .out_tag  (red_tag),
      .out_entry(red_entry)
   );

   gre_lane u_green (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .gamma    (green_g),
      .scale    (scale),
      .in_tag   (front_tag_ff),
      .in_mag   (front_mag_ff),
      .out_tag  (green_tag),
      .out_entry(green_entry)
   );

   gre_lane u_blue (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .gamma    (blue_g),
      .scale    (scale),
      .in_tag   (front_tag_ff),
      .in_mag   (front_mag_ff),
      .out_tag  (blue_tag),
      .out_entry(blue_entry)
   );

   assign push = adv & red_tag.valid;
   assign pop = main_valid_ff & rsp_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_r_in = main_r_ff;
      main_g_in = main_g_ff;
      main_b_in = main_b_ff;
      skid_r_in = skid_r_ff;
      skid_g_in = skid_g_ff;
      skid_b_in = skid_b_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_r_in = skid_r_ff;
            main_g_in = skid_g_ff;
            main_b_in = skid_b_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_r_in = red_entry;
            main_g_in = green_entry;
            main_b_in = blue_entry;
            main_valid_in = 1'b1;
         end else begin
            skid_r_in = red_entry;
            skid_g_in = green_entry;
            skid_b_in = blue_entry;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_r_ff <= main_r_in;
      main_g_ff <= main_g_in;
      main_b_ff <= main_b_in;
      skid_r_ff <= skid_r_in;
      skid_g_ff <= skid_g_in;
      skid_b_ff <= skid_b_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_red_entry = main_r_ff;
   assign rsp_green_entry = main_g_ff;
   assign rsp_blue_entry = main_b_ff;

`ifndef SYNTHESIS
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      (red_tag.valid == green_tag.valid) && (red_tag.valid == blue_tag.valid))
      else $error("colour lanes out of step");

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid register holds a beat while the output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid register did not drain after a taken beat");
`endif

endmodule

`default_nettype wire
